FILE: rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants and types for the video cover scale and crop block.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

    // Default width of every coordinate and size on the input side
    localparam int COORD_BITS_DEF = 12;

    // Scale is worked out in percent, then rounded to half steps
    localparam int PCT_ONE  = 100;
    localparam int PCT_HALF = 50;
    localparam int PCT_W    = $clog2(PCT_ONE);

    // Fixed widths of the result fields
    localparam int SCALE_W = 14;
    localparam int POS_W   = 25;
    localparam int SIZE_W  = 24;

    // Which percentage feeds the half-step rounding
    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_MAX,
        SEL_X,
        SEL_Y
    } t_pct_sel;

endpackage

`default_nettype wire

FILE: rtl/core/scp_in_if.sv
// ----------------------------------------------------------------------------
// scp_in_if
// Window request channel: frame size and display rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

interface scp_in_if import scp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
    logic [COORD_BITS-1:0] display_x;
    logic [COORD_BITS-1:0] display_y;
    logic [COORD_BITS-1:0] display_width;
    logic [COORD_BITS-1:0] display_height;

    modport source (
        output valid, frame_width, frame_height, display_x, display_y,
               display_width, display_height,
        input  ready
    );

    modport sink (
        input  valid, frame_width, frame_height, display_x, display_y,
               display_width, display_height,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/scp_out_if.sv
// ----------------------------------------------------------------------------
// scp_out_if
// Canvas result channel: scale, canvas origin and canvas size.
// ----------------------------------------------------------------------------
`default_nettype none

interface scp_out_if import scp_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic                      apply;
    logic [SCALE_W-1:0]        scale_half_steps;
    logic signed [POS_W-1:0]   canvas_x;
    logic signed [POS_W-1:0]   canvas_y;
    logic [SIZE_W-1:0]         canvas_width;
    logic [SIZE_W-1:0]         canvas_height;

    modport source (
        output valid, apply, scale_half_steps, canvas_x, canvas_y,
               canvas_width, canvas_height,
        input  ready
    );

    modport sink (
        input  valid, apply, scale_half_steps, canvas_x, canvas_y,
               canvas_width, canvas_height,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// side tag that travels in step with the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_div import scp_pkg::*; #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 12,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_quot,
    output logic [DEN_W-1:0]      o_rem,
    output logic [TAG_W-1:0]      o_tag
);
    localparam int W = DEN_W + NUM_W;

    // Upper DEN_W bits hold the partial remainder, lower NUM_W bits shift
    // the dividend out and the quotient in
    logic [W-1:0]     r_word  [NUM_W];
    logic [DEN_W-1:0] r_den   [NUM_W];
    logic [TAG_W-1:0] r_tag   [NUM_W];
    logic [NUM_W-1:0] r_valid;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [W-1:0]     w_prev;
        logic [DEN_W-1:0] w_den;
        logic [TAG_W-1:0] w_tag;
        logic             w_valid;
        logic [DEN_W:0]   w_top;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [W-1:0]     n_word;

        if (k == 0) begin : g_first
            assign w_prev  = {{DEN_W{1'b0}}, i_num};
            assign w_den   = i_den;
            assign w_tag   = i_tag;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_prev  = r_word[k-1];
            assign w_den   = r_den[k-1];
            assign w_tag   = r_tag[k-1];
            assign w_valid = r_valid[k-1];
        end

        assign w_top  = {w_prev[W-1 -: DEN_W], w_prev[NUM_W-1]};
        assign w_ge   = (w_top >= {1'b0, w_den});
        assign w_diff = w_top - {1'b0, w_den};
        assign n_word = {(w_ge ? w_diff[DEN_W-1:0] : w_top[DEN_W-1:0]),
                         w_prev[NUM_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_word[k] <= n_word;
                r_den[k]  <= w_den;
                r_tag[k]  <= w_tag;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quot  = r_word[NUM_W-1][NUM_W-1:0];
    assign o_rem   = r_word[NUM_W-1][W-1 -: DEN_W];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/video_cover_scale_and_crop.sv
// ----------------------------------------------------------------------------
// video_cover_scale_and_crop
// Picks a cover scale for a video frame on a display window, rounds it to
// half steps and gives the centred canvas rectangle.
// ----------------------------------------------------------------------------
//  Channel  Dir  Modport  Carries
//  i_in     in   sink     frame size, display position and size
//  o_out    out  source   apply, half-step scale, canvas origin and size
//
//  The pipeline is an input register, a one-bit-per-stage divider of
//  COORD_BITS+7 stages for the width and height percentages, a select stage,
//  two stages of reciprocal multiply to split off whole percent, rounding,
//  multiply and centring.
//  One transaction is accepted per cycle while the pipeline advances. The
//  whole pipeline advances while the output register is empty or being taken,
//  and holds as a unit when it is stalled. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module video_cover_scale_and_crop import scp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scp_in_if.sink    i_in,
    scp_out_if.source o_out
);
    localparam int CB  = COORD_BITS;
    localparam int PW  = CB + PCT_W;   // percentage width
    localparam int HW  = CB + 2;       // half-step count width
    localparam int MW  = HW + CB;      // product width
    localparam int CWW = MW - 1;       // canvas size width
    localparam int DW  = CWW + 1;      // signed centring width

    // Reciprocal of one hundred, rounded up; exact for every PW-bit percentage
    localparam int     RK  = PW + PCT_W;
    localparam longint RM  = ((longint'(1) << RK) + longint'(PCT_ONE) - 1)
                             / longint'(PCT_ONE);
    localparam int     MBW = $clog2(RM + 1);
    localparam int     PRW = PW + MBW;
    localparam int     QW  = PRW - RK;
    localparam logic [MBW-1:0] RECIP = MBW'(RM);

    typedef struct packed {
        t_pct_sel        sel;
        logic            zero;
        logic [CB-1:0]   fw;
        logic [CB-1:0]   px;
        logic [CB-1:0]   py;
        logic [CB-1:0]   dw;
        logic [CB-1:0]   dh;
    } t_meta_a;

    typedef struct packed {
        logic            zero;
        logic [CB-1:0]   fw;
        logic [CB-1:0]   fh;
        logic [CB-1:0]   px;
        logic [CB-1:0]   py;
        logic [CB-1:0]   dw;
        logic [CB-1:0]   dh;
    } t_meta_b;

    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- input stage ----------------
    t_pct_sel n_sel;
    logic     w_gtx, w_ltx, w_gty, w_lty;

    assign w_gtx = i_in.display_width  > i_in.frame_width;
    assign w_ltx = i_in.display_width  < i_in.frame_width;
    assign w_gty = i_in.display_height > i_in.frame_height;
    assign w_lty = i_in.display_height < i_in.frame_height;

    always_comb begin
        if (!w_gtx && !w_ltx && !w_gty && !w_lty) begin
            n_sel = SEL_ONE;
        end else if (w_ltx && !w_gty && !w_lty) begin
            n_sel = SEL_ONE;            // crop only across
        end else if (w_lty && !w_gtx && !w_ltx) begin
            n_sel = SEL_ONE;            // crop only down
        end else if ((w_gtx && w_gty) || (w_ltx && w_lty)) begin
            n_sel = SEL_MAX;
        end else if (w_gtx) begin
            n_sel = SEL_X;
        end else begin
            n_sel = SEL_Y;
        end
    end

    logic          r_s0_valid;
    t_meta_a       r_s0_meta;
    logic [CB-1:0] r_s0_fh;
    logic [PW-1:0] r_s0_numx;
    logic [PW-1:0] r_s0_numy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_meta.sel  <= n_sel;
            r_s0_meta.zero <= (i_in.frame_width == '0) || (i_in.frame_height == '0);
            r_s0_meta.fw   <= i_in.frame_width;
            r_s0_meta.px   <= i_in.display_x;
            r_s0_meta.py   <= i_in.display_y;
            r_s0_meta.dw   <= i_in.display_width;
            r_s0_meta.dh   <= i_in.display_height;
            r_s0_fh        <= i_in.frame_height;
            r_s0_numx      <= PW'(i_in.display_width)  * PW'(PCT_ONE);
            r_s0_numy      <= PW'(i_in.display_height) * PW'(PCT_ONE);
        end
    end

    // ---------------- percentage dividers ----------------
    logic          w_xv, w_yv;
    logic [PW-1:0] w_xp, w_yp;
    logic [CB-1:0] w_xrem, w_yrem;
    logic [$bits(t_meta_a)-1:0] w_xtag;
    logic [CB-1:0] w_ytag;

    scp_div #(.NUM_W(PW), .DEN_W(CB), .TAG_W($bits(t_meta_a))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_num   (r_s0_numx),
        .i_den   (r_s0_meta.fw),
        .i_tag   (r_s0_meta),
        .o_valid (w_xv),
        .o_quot  (w_xp),
        .o_rem   (w_xrem),
        .o_tag   (w_xtag)
    );

    scp_div #(.NUM_W(PW), .DEN_W(CB), .TAG_W(CB)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_num   (r_s0_numy),
        .i_den   (r_s0_fh),
        .i_tag   (r_s0_fh),
        .o_valid (w_yv),
        .o_quot  (w_yp),
        .o_rem   (w_yrem),
        .o_tag   (w_ytag)
    );

    // ---------------- select stage ----------------
    t_meta_a       w_xmeta;
    logic [PW-1:0] n_pct;

    assign w_xmeta = t_meta_a'(w_xtag);

    always_comb begin
        case (w_xmeta.sel)
            SEL_ONE: n_pct = PW'(PCT_ONE);
            SEL_MAX: n_pct = (w_xp > w_yp) ? w_xp : w_yp;
            SEL_X:   n_pct = w_xp;
            SEL_Y:   n_pct = w_yp;
            default: n_pct = PW'(PCT_ONE);
        endcase
    end

    logic          r_p_valid;
    logic [PW-1:0] r_p_pct;
    t_meta_b       r_p_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_xv && w_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_pct       <= n_pct;
            r_p_meta.zero <= w_xmeta.zero;
            r_p_meta.fw   <= w_xmeta.fw;
            r_p_meta.fh   <= w_ytag;
            r_p_meta.px   <= w_xmeta.px;
            r_p_meta.py   <= w_xmeta.py;
            r_p_meta.dw   <= w_xmeta.dw;
            r_p_meta.dh   <= w_xmeta.dh;
        end
    end

    // ---------------- split percentage into whole and hundredths ----------------
    // Multiply by the reciprocal, then take the hundredths back off
    logic           r_c_valid;
    logic [PRW-1:0] r_c_prod;
    logic [PW-1:0]  r_c_pct;
    t_meta_b        r_c_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_prod <= PRW'(r_p_pct) * PRW'(RECIP);
            r_c_pct  <= r_p_pct;
            r_c_meta <= r_p_meta;
        end
    end

    logic [QW-1:0] w_cq;
    logic [PW-1:0] w_crem;

    assign w_cq   = r_c_prod[PRW-1:RK];
    assign w_crem = r_c_pct - PW'(w_cq) * PW'(PCT_ONE);

    logic             r_q_valid;
    logic [QW-1:0]    r_q_quot;
    logic [PCT_W-1:0] r_q_rem;
    t_meta_b          r_q_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_q_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_quot <= w_cq;
            r_q_rem  <= w_crem[PCT_W-1:0];
            r_q_meta <= r_c_meta;
        end
    end

    // ---------------- half-step rounding ----------------
    logic [CB:0]   w_qn;
    logic [1:0]    w_inc;
    logic [HW-1:0] n_half;

    assign w_qn = r_q_quot[CB:0];

    always_comb begin
        if (r_q_rem > PCT_W'(PCT_HALF)) begin
            w_inc = 2'd2;
        end else if (r_q_rem != '0) begin
            w_inc = 2'd1;
        end else begin
            w_inc = 2'd0;
        end
        if (w_qn != '0) begin
            n_half = HW'({w_qn, 1'b0}) + HW'(w_inc);
        end else begin
            n_half = (w_inc == 2'd2) ? HW'(2) : HW'(1);
        end
    end

    logic          r_h_valid;
    logic [HW-1:0] r_h_half;
    t_meta_b       r_h_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_en) begin
            r_h_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_half <= n_half;
            r_h_meta <= r_q_meta;
        end
    end

    // ---------------- canvas size ----------------
    logic [MW-1:0] w_pw, w_ph;

    assign w_pw = MW'(r_h_half) * MW'(r_h_meta.fw);
    assign w_ph = MW'(r_h_half) * MW'(r_h_meta.fh);

    logic           r_m_valid;
    logic           r_m_zero;
    logic [HW-1:0]  r_m_half;
    logic [CWW-1:0] r_m_cw, r_m_ch;
    logic [CB-1:0]  r_m_px, r_m_py, r_m_dw, r_m_dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_zero <= r_h_meta.zero;
            r_m_half <= r_h_half;
            r_m_cw   <= w_pw[MW-1:1];
            r_m_ch   <= w_ph[MW-1:1];
            r_m_px   <= r_h_meta.px;
            r_m_py   <= r_h_meta.py;
            r_m_dw   <= r_h_meta.dw;
            r_m_dh   <= r_h_meta.dh;
        end
    end

    // ---------------- centring and output register ----------------
    logic signed [DW-1:0] w_dx, w_dy, w_sx, w_sy, w_cx, w_cy;

    // Halve toward zero: bias negative values by one before the shift
    assign w_dx = $signed(DW'(r_m_dw)) - $signed(DW'(r_m_cw));
    assign w_dy = $signed(DW'(r_m_dh)) - $signed(DW'(r_m_ch));
    assign w_sx = w_dx + $signed({{(DW-1){1'b0}}, w_dx[DW-1]});
    assign w_sy = w_dy + $signed({{(DW-1){1'b0}}, w_dy[DW-1]});
    assign w_cx = $signed(DW'(r_m_px)) + (w_sx >>> 1);
    assign w_cy = $signed(DW'(r_m_py)) + (w_sy >>> 1);

    logic                    r_o_valid;
    logic                    r_o_apply;
    logic [SCALE_W-1:0]      r_o_scale;
    logic signed [POS_W-1:0] r_o_cx, r_o_cy;
    logic [SIZE_W-1:0]       r_o_cw, r_o_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_m_zero) begin
                r_o_apply <= 1'b0;
                r_o_scale <= '0;
                r_o_cx    <= '0;
                r_o_cy    <= '0;
                r_o_cw    <= '0;
                r_o_ch    <= '0;
            end else begin
                r_o_apply <= 1'b1;
                r_o_scale <= SCALE_W'(r_m_half);
                r_o_cx    <= POS_W'(w_cx);
                r_o_cy    <= POS_W'(w_cy);
                r_o_cw    <= SIZE_W'(r_m_cw);
                r_o_ch    <= SIZE_W'(r_m_ch);
            end
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.apply            = r_o_apply;
    assign o_out.scale_half_steps = r_o_scale;
    assign o_out.canvas_x         = r_o_cx;
    assign o_out.canvas_y         = r_o_cy;
    assign o_out.canvas_width     = r_o_cw;
    assign o_out.canvas_height    = r_o_ch;

endmodule

`default_nettype wire

FILE: rtl/core/scp_check.sv
// ----------------------------------------------------------------------------
// scp_check
// Port-level checks on the cover scale and crop block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_check import scp_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic                    i_apply,
    input wire logic [SCALE_W-1:0]      i_scale,
    input wire logic signed [POS_W-1:0] i_cx,
    input wire logic signed [POS_W-1:0] i_cy,
    input wire logic [SIZE_W-1:0]       i_cw,
    input wire logic [SIZE_W-1:0]       i_ch
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result transaction present right after reset");

    // A free output side must never hold off the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input held off while output side is free");

    // Unknown frame size gives an all-zero result
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_apply) |->
            (i_scale == '0 && i_cx == '0 && i_cy == '0 && i_cw == '0 && i_ch == '0))
        else $error("result fields not cleared without apply");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_apply) && $stable(i_scale) && $stable(i_cx)
             && $stable(i_cy) && $stable(i_cw) && $stable(i_ch)))
        else $error("stalled result transaction changed");

endmodule

bind video_cover_scale_and_crop scp_check u_scp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_apply     (o_out.apply),
    .i_scale     (o_out.scale_half_steps),
    .i_cx        (o_out.canvas_x),
    .i_cy        (o_out.canvas_y),
    .i_cw        (o_out.canvas_width),
    .i_ch        (o_out.canvas_height)
);

`default_nettype wire

FILE: tb/video_cover_scale_and_crop_tb.sv
// ----------------------------------------------------------------------------
// video_cover_scale_and_crop_tb
// Self-checking bench for the cover scale and crop block. A directed list of
// window requests (unknown frame size, size extremes, every sign case of the
// size differences, every half-step rounding branch) is followed by random
// requests. Each result is checked field by field against typed values where
// a directed row gives them, else an in-bench model of the scale choice,
// half-step rounding and canvas centring. Both channels idle at random; the
// result side also holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_cover_scale_and_crop_tb;
    import scp_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int MAXC        = (1 << CB) - 1;
    localparam int LATENCY     = CB + 14;
    localparam int RAND_ITEMS  = 500;
    localparam int HOLD_CYCLES = 160;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t frame_width;
        coord_t frame_height;
        coord_t display_x;
        coord_t display_y;
        coord_t display_width;
        coord_t display_height;
    } request_t;

    typedef struct packed {
        logic                    apply;
        logic [SCALE_W-1:0]      scale_half_steps;
        logic signed [POS_W-1:0] canvas_x;
        logic signed [POS_W-1:0] canvas_y;
        logic [SIZE_W-1:0]       canvas_width;
        logic [SIZE_W-1:0]       canvas_height;
    } canvas_t;

    typedef struct {
        request_t rq;
        bit       typed;
        canvas_t  want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    scp_in_if #(.COORD_BITS(CB)) in_if ();
    scp_out_if                   out_if ();

    video_cover_scale_and_crop #(
        .COORD_BITS(CB)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    canvas_t canvas_q[$];
    int      cycle_count;
    int      err_count;
    int      sent_count;
    int      result_count;
    int      unknown_count;
    int      enlarge_count;
    int      shrink_count;
    int      unity_count;
    bit      gaps_on;
    bit      hold_req;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Cover scale: percentage from the sign case, rounded up to half steps
    function automatic canvas_t predict_canvas(request_t rq);
        canvas_t c;
        longint  fw, fh, px, py, dw, dh, dxw, dyh, xp, yp, pct, q, r, half, cw, ch;
        fw  = rq.frame_width;
        fh  = rq.frame_height;
        px  = rq.display_x;
        py  = rq.display_y;
        dw  = rq.display_width;
        dh  = rq.display_height;
        c   = '0;
        if (fw == 0 || fh == 0) begin
            return c;
        end
        dxw = dw - fw;
        dyh = dh - fh;
        xp  = (PCT_ONE * dw) / fw;
        yp  = (PCT_ONE * dh) / fh;
        if ((dxw > 0 && dyh > 0) || (dxw < 0 && dyh < 0)) begin
            pct = (xp > yp) ? xp : yp;
        end else if (dxw > 0) begin
            pct = xp;
        end else if (dyh > 0) begin
            pct = yp;
        end else begin
            // equal, or crop along one axis only
            pct = PCT_ONE;
        end
        q = pct / PCT_ONE;
        r = pct % PCT_ONE;
        if (q > 0) begin
            half = 2 * q + ((r > PCT_HALF) ? 2 : (r > 0) ? 1 : 0);
        end else begin
            half = (r > PCT_HALF) ? 2 : 1;
        end
        cw = (half * fw) / 2;
        ch = (half * fh) / 2;
        c.apply            = 1'b1;
        c.scale_half_steps = SCALE_W'(half);
        c.canvas_x         = POS_W'(px + (dw - cw) / 2);
        c.canvas_y         = POS_W'(py + (dh - ch) / 2);
        c.canvas_width     = SIZE_W'(cw);
        c.canvas_height    = SIZE_W'(ch);
        return c;
    endfunction

    function automatic dir_row_t window_row(int fw, int fh, int px, int py, int dw, int dh,
                                            bit typed = 1'b0, int h = 0, int cx = 0,
                                            int cy = 0, int cw = 0, int ch = 0);
        dir_row_t row;
        row.rq                  = '{coord_t'(fw), coord_t'(fh), coord_t'(px), coord_t'(py),
                                    coord_t'(dw), coord_t'(dh)};
        row.typed               = typed;
        row.want.apply          = (fw != 0 && fh != 0);
        row.want.scale_half_steps = SCALE_W'(h);
        row.want.canvas_x       = POS_W'(cx);
        row.want.canvas_y       = POS_W'(cy);
        row.want.canvas_width   = SIZE_W'(cw);
        row.want.canvas_height  = SIZE_W'(ch);
        return row;
    endfunction

    function automatic coord_t clamp_coord(int v, int lo);
        if (v < lo) begin
            return coord_t'(lo);
        end
        if (v > MAXC) begin
            return coord_t'(MAXC);
        end
        return coord_t'(v);
    endfunction

    function automatic request_t rand_request();
        request_t rq;
        int       sel;
        sel               = $urandom_range(0, 99);
        rq.display_x      = coord_t'($urandom_range(0, MAXC));
        rq.display_y      = coord_t'($urandom_range(0, MAXC));
        rq.frame_width    = coord_t'($urandom_range(1, MAXC));
        rq.frame_height   = coord_t'($urandom_range(1, MAXC));
        rq.display_width  = coord_t'($urandom_range(0, MAXC));
        rq.display_height = coord_t'($urandom_range(0, MAXC));
        if (sel < 25) begin
            // full range, frames may be zero
            rq.frame_width  = coord_t'($urandom_range(0, MAXC));
            rq.frame_height = coord_t'($urandom_range(0, MAXC));
        end else if (sel < 65) begin
            // display close to frame: hits every sign case, equality included
            rq.display_width  = clamp_coord(int'(rq.frame_width) +
                                            $urandom_range(0, 6) - 3, 0);
            rq.display_height = clamp_coord(int'(rq.frame_height) +
                                            $urandom_range(0, 6) - 3, 0);
        end else if (sel < 80) begin
            rq.frame_width  = coord_t'($urandom_range(1, 64));
            rq.frame_height = coord_t'($urandom_range(1, 64));
        end else if (sel < 95) begin
            rq.display_width  = coord_t'($urandom_range(0, 128));
            rq.display_height = coord_t'($urandom_range(0, 128));
        end else if (sel < 98) begin
            rq.frame_width = '0;
        end else begin
            rq.frame_height = '0;
        end
        return rq;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        err_count++;
    endtask

    // Offer one request, idling first at random; log the expectation on transaction
    task automatic drive_request(request_t rq, canvas_t want);
        while (gaps_on && $urandom_range(0, 99) < 37) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.frame_width    <= rq.frame_width;
        in_if.frame_height   <= rq.frame_height;
        in_if.display_x      <= rq.display_x;
        in_if.display_y      <= rq.display_y;
        in_if.display_width  <= rq.display_width;
        in_if.display_height <= rq.display_height;
        do begin
            @(posedge clk);
        end while (!in_if.ready);
        canvas_q.push_back(want);
        sent_count++;
    endtask

    task automatic check_canvas(canvas_t got);
        canvas_t want;
        if (canvas_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      result_count));
            return;
        end
        want = canvas_q.pop_front();
        if (got.apply !== want.apply)
            report_mismatch($sformatf("result %0d apply got %0b want %0b",
                                      result_count, got.apply, want.apply));
        if (got.scale_half_steps !== want.scale_half_steps)
            report_mismatch($sformatf("result %0d scale_half_steps got %0d want %0d",
                                      result_count, got.scale_half_steps,
                                      want.scale_half_steps));
        if (got.canvas_x !== want.canvas_x)
            report_mismatch($sformatf("result %0d canvas_x got %0d want %0d",
                                      result_count, got.canvas_x, want.canvas_x));
        if (got.canvas_y !== want.canvas_y)
            report_mismatch($sformatf("result %0d canvas_y got %0d want %0d",
                                      result_count, got.canvas_y, want.canvas_y));
        if (got.canvas_width !== want.canvas_width)
            report_mismatch($sformatf("result %0d canvas_width got %0d want %0d",
                                      result_count, got.canvas_width,
                                      want.canvas_width));
        if (got.canvas_height !== want.canvas_height)
            report_mismatch($sformatf("result %0d canvas_height got %0d want %0d",
                                      result_count, got.canvas_height,
                                      want.canvas_height));
        if (!want.apply) begin
            unknown_count++;
        end else if (want.scale_half_steps > 2) begin
            enlarge_count++;
        end else if (want.scale_half_steps < 2) begin
            shrink_count++;
        end else begin
            unity_count++;
        end
    endtask

    // Result side: take transactions, stall at random, hold off once for a long stretch
    initial begin
        bit hold_started;
        int hold_left;
        bit rdy;
        hold_started = 1'b0;
        hold_left    = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                check_canvas('{out_if.apply, out_if.scale_half_steps, out_if.canvas_x,
                               out_if.canvas_y, out_if.canvas_width,
                               out_if.canvas_height});
                result_count++;
            end
            if (hold_req && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = !(gaps_on && $urandom_range(0, 99) < 37);
            end
            out_if.ready <= rdy;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
        end
        $display("** video_cover_scale_and_crop: FAILED **");
        $finish;
    end

    initial begin
        dir_row_t dir_rows[$];
        request_t rq;
        canvas_t  want;

        cycle_count          = 0;
        err_count            = 0;
        sent_count           = 0;
        result_count         = 0;
        unknown_count        = 0;
        enlarge_count        = 0;
        shrink_count         = 0;
        unity_count          = 0;
        gaps_on              = 1'b1;
        hold_req             = 1'b0;
        rst_n                <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.frame_width    <= '0;
        in_if.frame_height   <= '0;
        in_if.display_x      <= '0;
        in_if.display_y      <= '0;
        in_if.display_width  <= '0;
        in_if.display_height <= '0;

        // unknown frame size
        dir_rows.push_back(window_row(0, 480, 5, 6, 640, 480, 1'b1));
        dir_rows.push_back(window_row(640, 0, 5, 6, 640, 480, 1'b1));
        dir_rows.push_back(window_row(0, 0, MAXC, MAXC, MAXC, MAXC, 1'b1));
        // same size: unity scale, canvas on the window
        dir_rows.push_back(window_row(100, 100, 10, 20, 100, 100, 1'b1, 2, 10, 20, 100, 100));
        dir_rows.push_back(window_row(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1,
                                      2, MAXC, MAXC, MAXC, MAXC));
        // largest enlargement and smallest shrink
        dir_rows.push_back(window_row(1, 1, 0, 0, MAXC, MAXC, 1'b1,
                                      2 * MAXC, 0, 0, MAXC, MAXC));
        dir_rows.push_back(window_row(MAXC, MAXC, 0, 0, 1, 1, 1'b1,
                                      1, -1023, -1023, 2047, 2047));
        // each sign case of the width and height differences
        dir_rows.push_back(window_row(640, 480, 0, 0, 320, 480));
        dir_rows.push_back(window_row(640, 480, 7, 9, 640, 240));
        dir_rows.push_back(window_row(320, 240, 30, 40, 1280, 600));
        dir_rows.push_back(window_row(1920, 1080, 100, 50, 800, 600));
        dir_rows.push_back(window_row(100, 100, 0, 0, 150, 100));
        dir_rows.push_back(window_row(100, 200, 3, 3, 151, 100));
        dir_rows.push_back(window_row(100, 100, 0, 0, 100, 175));
        dir_rows.push_back(window_row(200, 100, 1, 2, 50, 199));
        // rounding: below one, exact multiples, odd sizes
        dir_rows.push_back(window_row(100, 100, 0, 0, 60, 60));
        dir_rows.push_back(window_row(100, 100, 0, 0, 50, 50));
        dir_rows.push_back(window_row(100, 100, 0, 0, 300, 300));
        dir_rows.push_back(window_row(3, 7, 11, 13, MAXC, MAXC));
        dir_rows.push_back(window_row(1, MAXC, MAXC, MAXC, MAXC, 0));
        dir_rows.push_back(window_row(MAXC, 1, 0, MAXC, 0, MAXC));
        dir_rows.push_back(window_row('hAAA, 'h555, 'h555, 'hAAA, 'h555, 'hAAA));
        dir_rows.push_back(window_row('h555, 'hAAA, 'hAAA, 'h555, 'hAAA, 'h555));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            want = dir_rows[i].typed ? dir_rows[i].want : predict_canvas(dir_rows[i].rq);
            drive_request(dir_rows[i].rq, want);
        end
        in_if.valid <= 1'b0;
        while (canvas_q.size() != 0) @(posedge clk);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 60) begin
                hold_req = 1'b1;
            end
            gaps_on = !(n >= 150 && n < 250);
            if (n == 350) begin
                // drain the pipeline before going on
                in_if.valid <= 1'b0;
                while (canvas_q.size() != 0) @(posedge clk);
            end
            rq = rand_request();
            drive_request(rq, predict_canvas(rq));
        end
        in_if.valid <= 1'b0;

        while (canvas_q.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("Sent %0d window requests (%0d directed), checked %0d canvas results.",
                 sent_count, dir_rows.size(), result_count);
        $display("Scales seen: %0d enlarging, %0d shrinking, %0d unity, %0d unknown frame.",
                 enlarge_count, shrink_count, unity_count, unknown_count);
        if (err_count == 0) begin
            $display("** video_cover_scale_and_crop: PASSED **");
        end else begin
            $display("** video_cover_scale_and_crop: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/scp_pkg.sv
rtl/core/scp_in_if.sv
rtl/core/scp_out_if.sv
rtl/core/scp_div.sv
rtl/core/video_cover_scale_and_crop.sv
rtl/core/scp_check.sv
tb/video_cover_scale_and_crop_tb.sv
